[hw/rtl/clip_rectangle_stack_macros.svh]
// Assertion macros for the clip rectangle stack.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef CLIP_RECTANGLE_STACK_MACROS_SVH
`define CLIP_RECTANGLE_STACK_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define CRS_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("clip stack invariant violated");

// An implication checked in the same cycle.
`define CRS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("clip stack check failed");

// An implication checked in the next cycle.
`define CRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("clip stack sequencing violated");

`endif

[hw/rtl/crs_pkg.sv]
// Types and codes for the clip rectangle stack.
// No dependencies.
`default_nettype none

package crs_pkg;

    typedef enum logic [1:0] {
        F_BEGIN = 2'd0,
        F_END   = 2'd1,
        F_PUSH  = 2'd2,
        F_POP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_INVALID = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_ISECT = 5'b00100,
        S_POPRD = 5'b01000,
        S_RESP  = 5'b10000
    } state_t;

    typedef struct packed {
        logic        [30:0] h;
        logic        [30:0] w;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } rect_t;

    localparam int IN_BYTES  = 17;
    localparam int OUT_BYTES = 17;

endpackage

`default_nettype wire

[hw/rtl/clip_rectangle_stack.sv]
// Clip rectangle stack of a 2D renderer, top level; uses crs_pkg and the assertion macros.
// Each input beat carries one operation (begin frame, end frame, push clip, pop clip) and
// produces exactly one result beat with the status, the current clip, the depth and the frame
// flag. The stacked rectangles live in a memory of MAX_CLIPS entries with a registered read;
// a copy of the top entry is held in a register so that push needs no read. A beat is taken
// only in S_IDLE. Begin, end and rejected operations pass S_EXEC and S_RESP; a push also
// passes S_ISECT because the intersection is computed in two steps, and a pop S_POPRD because
// it waits for the memory read of the new top. A result beat that is not taken holds only the
// next result, not the next input. No memory clearing pass is needed after reset.
`default_nettype none
`include "clip_rectangle_stack_macros.svh"

module clip_rectangle_stack
    import crs_pkg::*;
#(
    parameter int MAX_CLIPS = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // func[1:0], rect_x[33:2], rect_y[65:34], rect_w[97:66], rect_h[129:98], zero fill
    input  wire logic [IN_BYTES*8-1:0]    s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // status[1:0], clip_x[33:2], clip_y[65:34], clip_w[96:66], clip_h[127:97],
    // depth[132:128], frame_open[133], zero fill
    output logic [OUT_BYTES*8-1:0]        m_tdata
);

    localparam int DW = $clog2(MAX_CLIPS + 1);
    localparam int AW = $clog2(MAX_CLIPS);

    state_t             state_reg, state_next;
    func_t              op_reg;
    logic signed [31:0] rx_reg, ry_reg, rw_reg, rh_reg;
    logic               frame_reg, frame_next;
    logic [DW-1:0]      depth_reg, depth_next;
    logic [DW-1:0]      depth_m2;
    logic [DW+4:0]      depth_ext;
    rect_t              top_reg, top_next;
    rect_t              root_rect, isect_rect, out_rect;
    status_t            status_reg, status_next;
    logic signed [33:0] right_reg, right_next, bottom_reg, bottom_next;
    logic signed [31:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [33:0] p_right, r_right, p_bottom, r_bottom, w_diff, h_diff;
    logic               m_valid_reg, m_valid_next;
    logic [OUT_BYTES*8-1:0] m_data_reg, m_data_next;
    logic               load_out;

    rect_t              mem [MAX_CLIPS];
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    rect_t              mem_wdata, rd_data_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb begin
        p_right     = $signed({{2{top_reg.x[31]}}, top_reg.x}) + $signed({3'b000, top_reg.w});
        r_right     = $signed({{2{rx_reg[31]}}, rx_reg}) + $signed({{2{rw_reg[31]}}, rw_reg});
        p_bottom    = $signed({{2{top_reg.y[31]}}, top_reg.y}) + $signed({3'b000, top_reg.h});
        r_bottom    = $signed({{2{ry_reg[31]}}, ry_reg}) + $signed({{2{rh_reg[31]}}, rh_reg});
        right_next  = (p_right < r_right) ? p_right : r_right;
        bottom_next = (p_bottom < r_bottom) ? p_bottom : r_bottom;
        cx_next     = (top_reg.x > rx_reg) ? top_reg.x : rx_reg;
        cy_next     = (top_reg.y > ry_reg) ? top_reg.y : ry_reg;
    end

    always_comb begin
        w_diff       = right_reg - $signed({{2{cx_reg[31]}}, cx_reg});
        h_diff       = bottom_reg - $signed({{2{cy_reg[31]}}, cy_reg});
        isect_rect.x = cx_reg;
        isect_rect.y = cy_reg;
        isect_rect.w = (w_diff > 0) ? w_diff[30:0] : '0;
        isect_rect.h = (h_diff > 0) ? h_diff[30:0] : '0;
        root_rect.x  = rx_reg;
        root_rect.y  = ry_reg;
        root_rect.w  = (rw_reg > 0) ? rw_reg[30:0] : '0;
        root_rect.h  = (rh_reg > 0) ? rh_reg[30:0] : '0;
    end

    assign depth_m2  = depth_reg - DW'(2);
    assign depth_ext = {5'b00000, depth_reg};
    assign out_rect  = frame_reg ? top_reg : '0;
    assign load_out  = (state_reg == S_RESP) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next  = state_reg;
        frame_next  = frame_reg;
        depth_next  = depth_reg;
        top_next    = top_reg;
        status_next = status_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = '0;
        mem_raddr   = depth_m2[AW-1:0];
        mem_wdata   = root_rect;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                status_next = ST_OK;
                state_next  = S_RESP;
                case (op_reg)
                    F_BEGIN: begin
                        if (frame_reg) begin
                            status_next = ST_BUSY;
                        end else begin
                            mem_we     = 1'b1;
                            top_next   = root_rect;
                            depth_next = DW'(1);
                            frame_next = 1'b1;
                        end
                    end
                    F_END: begin
                        if (!frame_reg) begin
                            status_next = ST_BUSY;
                        end else begin
                            depth_next = '0;
                            frame_next = 1'b0;
                        end
                    end
                    F_PUSH: begin
                        if (!frame_reg || rw_reg <= 0 || rh_reg <= 0) begin
                            status_next = ST_INVALID;
                        end else if (depth_reg >= DW'(MAX_CLIPS)) begin
                            status_next = ST_BUSY;
                        end else begin
                            state_next = S_ISECT;
                        end
                    end
                    F_POP: begin
                        if (!frame_reg || depth_reg <= DW'(1)) begin
                            status_next = ST_INVALID;
                        end else begin
                            mem_re     = 1'b1;
                            depth_next = depth_reg - DW'(1);
                            state_next = S_POPRD;
                        end
                    end
                    default: begin
                        status_next = ST_INVALID;
                    end
                endcase
            end
            S_ISECT: begin
                mem_we     = 1'b1;
                mem_waddr  = depth_reg[AW-1:0];
                mem_wdata  = isect_rect;
                top_next   = isect_rect;
                depth_next = depth_reg + DW'(1);
                state_next = S_RESP;
            end
            S_POPRD: begin
                top_next   = rd_data_reg;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = load_out || (m_valid_reg && !m_tready);
        m_data_next  = m_data_reg;
        if (load_out) begin
            m_data_next = {2'b00, frame_reg, depth_ext[4:0], out_rect, status_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            frame_reg   <= 1'b0;
            depth_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            frame_reg   <= frame_next;
            depth_reg   <= depth_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg <= func_t'(s_tdata[1:0]);
            rx_reg <= s_tdata[33:2];
            ry_reg <= s_tdata[65:34];
            rw_reg <= s_tdata[97:66];
            rh_reg <= s_tdata[129:98];
        end
        top_reg    <= top_next;
        status_reg <= status_next;
        right_reg  <= right_next;
        bottom_reg <= bottom_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        m_data_reg <= m_data_next;
    end

    `CRS_ASSERT_ALWAYS(a_frame_depth, aclk, aresetn, frame_reg == (depth_reg != '0))
    `CRS_ASSERT_ALWAYS(a_depth_max, aclk, aresetn, depth_reg <= DW'(MAX_CLIPS))
    `CRS_ASSERT_NEXT(a_push_grows, aclk, aresetn, state_reg == S_ISECT, depth_reg == $past(depth_reg) + DW'(1))
    `CRS_ASSERT_IMPL(a_out_from_resp, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == S_RESP)

endmodule

`default_nettype wire
